FILE: rtl/core/msr_pkg.sv
// package for the modular square root block: field widths, limits, state types
// no dependencies
`timescale 1ns / 1ps

package msr_pkg;

    localparam int FIELD_BITS = 32;
    localparam int NR_LIMIT   = 256;
    localparam int Z_BITS     = 9;

    typedef enum logic [2:0] {
        EX_IDLE,
        EX_RED,
        EX_STEP,
        EX_MULR,
        EX_SQ
    } msr_exp_state_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WAIT,
        ST_EULER,
        ST_SPLIT,
        ST_ROOT3,
        ST_ZTRY,
        ST_ZCHK,
        ST_CSET,
        ST_TSET,
        ST_RSET,
        ST_LOOP,
        ST_ISRCH,
        ST_BSQ,
        ST_BUPD,
        ST_CNEW,
        ST_TNEW,
        ST_RNEW,
        ST_DONE
    } msr_state_t;

endpackage

FILE: rtl/core/msr_req_if.sv
// request channel: valid/ready with value and modulus
// depends on msr_pkg
`timescale 1ns / 1ps

interface msr_req_if;
    logic                           valid;
    logic                           ready;
    logic [msr_pkg::FIELD_BITS-1:0] value;
    logic [msr_pkg::FIELD_BITS-1:0] modulus;

    modport source (output valid, output value, output modulus, input ready);
    modport sink (input valid, input value, input modulus, output ready);
endinterface

FILE: rtl/core/msr_rsp_if.sv
// response channel: valid/ready with root and residue flag
// depends on msr_pkg
`timescale 1ns / 1ps

interface msr_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [msr_pkg::FIELD_BITS-1:0] root;
    logic                           is_residue;

    modport source (output valid, output root, output is_residue, input ready);
    modport sink (input valid, input root, input is_residue, output ready);
endinterface

FILE: rtl/core/modular_square_root.sv
// modular square root: zero value or modulus below 3 goes straight to the done state and
// from there to the output register; otherwise each step is a modular exponentiation of up
// to 2*WORD_BITS multiplications on one shared bit-serial multiplier (two
// exponentiations, Euler test and root, for p = 3 mod 4)
// one item at a time; next beat taken once the result is in the output register
// asynchronous active-low reset returns the sequencer to idle and drops rsp valid
`timescale 1ns / 1ps

module modular_square_root #(
    parameter int WORD_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    msr_req_if.sink   req,
    msr_rsp_if.source rsp
);

    localparam int CW = $clog2(WORD_BITS + 1);
    localparam int ZB = msr_pkg::Z_BITS;

    msr_pkg::msr_state_t state_reg, state_next;
    msr_pkg::msr_state_t ret_reg, ret_next;

    logic [WORD_BITS-1:0] a_reg, a_next;
    logic [WORD_BITS-1:0] p_reg, p_next;
    logic [WORD_BITS-1:0] q_reg, q_next;
    logic [WORD_BITS-1:0] c_reg, c_next;
    logic [WORD_BITS-1:0] t_reg, t_next;
    logic [WORD_BITS-1:0] r_reg, r_next;
    logic [WORD_BITS-1:0] b_reg, b_next;
    logic [CW-1:0]        s_reg, s_next;
    logic [CW-1:0]        m_reg, m_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [CW-1:0]        j_reg, j_next;
    logic [ZB-1:0]        z_reg, z_next;
    logic [WORD_BITS-1:0] fin_root_reg, fin_root_next;
    logic                 fin_ok_reg, fin_ok_next;
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0] root_reg, root_next;
    logic                 ok_reg, ok_next;

    logic                 ex_start;
    logic [WORD_BITS-1:0] ex_base;
    logic [WORD_BITS-1:0] ex_exp;
    logic [WORD_BITS-1:0] ex_r0;
    logic [WORD_BITS-1:0] ex_p;
    logic                 ex_busy;
    logic                 ex_done;
    logic [WORD_BITS-1:0] ex_result;

    logic [WORD_BITS-1:0] in_a;
    logic [WORD_BITS-1:0] in_p;
    logic [WORD_BITS-1:0] pm1;
    logic [WORD_BITS:0]   pp1;
    logic [WORD_BITS:0]   qp1;
    logic [CW:0]          jsum;
    logic [WORD_BITS-1:0] one_w;
    logic [WORD_BITS-1:0] two_w;

    msr_mexp #(.WORD_BITS(WORD_BITS)) u_mexp (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ex_start),
        .base    (ex_base),
        .exp_val (ex_exp),
        .r0      (ex_r0),
        .p       (ex_p),
        .busy    (ex_busy),
        .done    (ex_done),
        .result  (ex_result)
    );

    assign in_a  = req.value[WORD_BITS-1:0];
    assign in_p  = req.modulus[WORD_BITS-1:0];
    assign pm1   = p_reg - 1'b1;
    assign pp1   = {1'b0, p_reg} + 1'b1;
    assign qp1   = {1'b0, q_reg} + 1'b1;
    assign jsum  = {1'b0, j_reg} + {1'b0, i_reg} + 1'b1;
    assign one_w = WORD_BITS'(1);
    assign two_w = WORD_BITS'(2);
    assign ex_p  = (state_reg == msr_pkg::ST_IDLE) ? in_p : p_reg;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        a_next         = a_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        c_next         = c_reg;
        t_next         = t_reg;
        r_next         = r_reg;
        b_next         = b_reg;
        s_next         = s_reg;
        m_next         = m_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        z_next         = z_reg;
        fin_root_next  = fin_root_reg;
        fin_ok_next    = fin_ok_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        root_next      = root_reg;
        ok_next        = ok_reg;
        ex_start       = 1'b0;
        ex_base        = a_reg;
        ex_exp         = two_w;
        ex_r0          = one_w;
        req.ready      = 1'b0;
        unique case (state_reg)
            msr_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    a_next = in_a;
                    p_next = in_p;
                    priority if (in_a == '0)
                    begin
                        fin_root_next = '0;
                        fin_ok_next   = 1'b1;
                        state_next    = msr_pkg::ST_DONE;
                    end
                    else if (in_p < two_w)
                    begin
                        fin_root_next = '0;
                        fin_ok_next   = 1'b0;
                        state_next    = msr_pkg::ST_DONE;
                    end
                    else if (in_p == two_w)
                    begin
                        fin_root_next = WORD_BITS'(in_a[0]);
                        fin_ok_next   = 1'b1;
                        state_next    = msr_pkg::ST_DONE;
                    end
                    else
                    begin
                        ex_start   = 1'b1;
                        ex_base    = in_a;
                        ex_exp     = (in_p - 1'b1) >> 1;
                        ret_next   = msr_pkg::ST_EULER;
                        state_next = msr_pkg::ST_WAIT;
                    end
                end
            end
            msr_pkg::ST_WAIT:
            begin
                if (ex_done)
                begin
                    state_next = ret_reg;
                end
            end
            msr_pkg::ST_EULER:
            begin
                if (ex_result != one_w)
                begin
                    fin_root_next = '0;
                    fin_ok_next   = 1'b0;
                    state_next    = msr_pkg::ST_DONE;
                end
                else
                begin
                    q_next     = pm1;
                    s_next     = '0;
                    state_next = msr_pkg::ST_SPLIT;
                end
            end
            msr_pkg::ST_SPLIT:
            begin
                if (!q_reg[0])
                begin
                    q_next = q_reg >> 1;
                    s_next = s_reg + 1'b1;
                end
                else if (s_reg == CW'(1))
                begin
                    ex_start   = 1'b1;
                    ex_exp     = pp1[WORD_BITS:2];
                    ret_next   = msr_pkg::ST_ROOT3;
                    state_next = msr_pkg::ST_WAIT;
                end
                else
                begin
                    z_next     = ZB'(2);
                    state_next = msr_pkg::ST_ZTRY;
                end
            end
            msr_pkg::ST_ROOT3:
            begin
                fin_root_next = ex_result;
                fin_ok_next   = 1'b1;
                state_next    = msr_pkg::ST_DONE;
            end
            msr_pkg::ST_ZTRY:
            begin
                if (WORD_BITS'(z_reg) < p_reg && z_reg < ZB'(msr_pkg::NR_LIMIT))
                begin
                    ex_start   = 1'b1;
                    ex_base    = WORD_BITS'(z_reg);
                    ex_exp     = pm1 >> 1;
                    ret_next   = msr_pkg::ST_ZCHK;
                    state_next = msr_pkg::ST_WAIT;
                end
                else
                begin
                    fin_root_next = '0;
                    fin_ok_next   = 1'b0;
                    state_next    = msr_pkg::ST_DONE;
                end
            end
            msr_pkg::ST_ZCHK:
            begin
                if (ex_result == pm1)
                begin
                    ex_start   = 1'b1;
                    ex_base    = WORD_BITS'(z_reg);
                    ex_exp     = q_reg;
                    ret_next   = msr_pkg::ST_CSET;
                    state_next = msr_pkg::ST_WAIT;
                end
                else
                begin
                    z_next     = z_reg + 1'b1;
                    state_next = msr_pkg::ST_ZTRY;
                end
            end
            msr_pkg::ST_CSET:
            begin
                c_next     = ex_result;
                ex_start   = 1'b1;
                ex_exp     = q_reg;
                ret_next   = msr_pkg::ST_TSET;
                state_next = msr_pkg::ST_WAIT;
            end
            msr_pkg::ST_TSET:
            begin
                t_next     = ex_result;
                ex_start   = 1'b1;
                ex_exp     = qp1[WORD_BITS:1];
                ret_next   = msr_pkg::ST_RSET;
                state_next = msr_pkg::ST_WAIT;
            end
            msr_pkg::ST_RSET:
            begin
                r_next     = ex_result;
                m_next     = s_reg;
                state_next = msr_pkg::ST_LOOP;
            end
            msr_pkg::ST_LOOP:
            begin
                if (t_reg == one_w)
                begin
                    fin_root_next = r_reg;
                    fin_ok_next   = 1'b1;
                    state_next    = msr_pkg::ST_DONE;
                end
                else
                begin
                    i_next     = CW'(1);
                    ex_start   = 1'b1;
                    ex_base    = t_reg;
                    ret_next   = msr_pkg::ST_ISRCH;
                    state_next = msr_pkg::ST_WAIT;
                end
            end
            msr_pkg::ST_ISRCH:
            begin
                priority if (ex_result != one_w && i_reg < m_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    ex_start   = 1'b1;
                    ex_base    = ex_result;
                    ret_next   = msr_pkg::ST_ISRCH;
                    state_next = msr_pkg::ST_WAIT;
                end
                else if (i_reg >= m_reg)
                begin
                    fin_root_next = '0;
                    fin_ok_next   = 1'b0;
                    state_next    = msr_pkg::ST_DONE;
                end
                else
                begin
                    b_next     = c_reg;
                    j_next     = '0;
                    state_next = msr_pkg::ST_BSQ;
                end
            end
            msr_pkg::ST_BSQ:
            begin
                ex_start   = 1'b1;
                ex_base    = b_reg;
                state_next = msr_pkg::ST_WAIT;
                if (jsum < {1'b0, m_reg})
                begin
                    ret_next = msr_pkg::ST_BUPD;
                end
                else
                begin
                    m_next   = i_reg;
                    ret_next = msr_pkg::ST_CNEW;
                end
            end
            msr_pkg::ST_BUPD:
            begin
                b_next     = ex_result;
                j_next     = j_reg + 1'b1;
                state_next = msr_pkg::ST_BSQ;
            end
            msr_pkg::ST_CNEW:
            begin
                c_next     = ex_result;
                ex_start   = 1'b1;
                ex_base    = ex_result;
                ex_exp     = one_w;
                ex_r0      = t_reg;
                ret_next   = msr_pkg::ST_TNEW;
                state_next = msr_pkg::ST_WAIT;
            end
            msr_pkg::ST_TNEW:
            begin
                t_next     = ex_result;
                ex_start   = 1'b1;
                ex_base    = b_reg;
                ex_exp     = one_w;
                ex_r0      = r_reg;
                ret_next   = msr_pkg::ST_RNEW;
                state_next = msr_pkg::ST_WAIT;
            end
            msr_pkg::ST_RNEW:
            begin
                r_next     = ex_result;
                state_next = msr_pkg::ST_LOOP;
            end
            msr_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    root_next      = fin_root_reg;
                    ok_next        = fin_ok_reg;
                    state_next     = msr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msr_pkg::ST_IDLE;
            ret_reg       <= msr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        c_reg        <= c_next;
        t_reg        <= t_next;
        r_reg        <= r_next;
        b_reg        <= b_next;
        s_reg        <= s_next;
        m_reg        <= m_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        z_reg        <= z_next;
        fin_root_reg <= fin_root_next;
        fin_ok_reg   <= fin_ok_next;
        root_reg     <= root_next;
        ok_reg       <= ok_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.root       = msr_pkg::FIELD_BITS'(root_reg);
    assign rsp.is_residue = ok_reg;

    a_nonres_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !ok_reg |-> root_reg == '0)
        else $error("non-residue with nonzero root");
    a_call_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ex_start |-> !ex_busy)
        else $error("exponentiation started while busy");
    a_wait_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == msr_pkg::ST_WAIT |-> ex_busy || ex_done)
        else $error("waiting on idle exponentiation unit");

endmodule

FILE: rtl/core/msr_mmul.sv
// bit-serial modular multiplier, one bit of x per cycle, msb first
// needs y < p; no package dependency
`timescale 1ns / 1ps

module msr_mmul #(
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] x,
    input  logic [WORD_BITS-1:0] y,
    input  logic [WORD_BITS-1:0] p,
    output logic                 done,
    output logic [WORD_BITS-1:0] prod
);

    localparam int CW = $clog2(WORD_BITS + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CW-1:0]        cnt_reg;
    logic [WORD_BITS-1:0] x_reg;
    logic [WORD_BITS-1:0] y_reg;
    logic [WORD_BITS-1:0] p_reg;
    logic [WORD_BITS-1:0] acc_reg;
    logic [WORD_BITS:0]   dbl;
    logic [WORD_BITS:0]   red1;
    logic [WORD_BITS:0]   add;
    logic [WORD_BITS:0]   red2;
    logic [WORD_BITS-1:0] acc_next;

    always_comb
    begin
        dbl      = {acc_reg, 1'b0};
        red1     = (dbl >= {1'b0, p_reg}) ? dbl - {1'b0, p_reg} : dbl;
        add      = red1 + (x_reg[WORD_BITS-1] ? {1'b0, y_reg} : '0);
        red2     = (add >= {1'b0, p_reg}) ? add - {1'b0, p_reg} : add;
        acc_next = red2[WORD_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(WORD_BITS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            y_reg   <= y;
            p_reg   <= p;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg   <= {x_reg[WORD_BITS-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

    a_prod_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> acc_reg < p_reg)
        else $error("product not reduced");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cnt_reg != CW'(WORD_BITS - 1) |=> busy_reg || start)
        else $error("multiplier stopped early");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held");

endmodule

FILE: rtl/core/msr_mexp.sv
// modular exponentiation r0 * base^exp mod p, right-to-left square and multiply
// depends on msr_pkg and msr_mmul
`timescale 1ns / 1ps

module msr_mexp #(
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] base,
    input  logic [WORD_BITS-1:0] exp_val,
    input  logic [WORD_BITS-1:0] r0,
    input  logic [WORD_BITS-1:0] p,
    output logic                 busy,
    output logic                 done,
    output logic [WORD_BITS-1:0] result
);

    msr_pkg::msr_exp_state_t state_reg, state_next;
    logic                 done_reg, done_next;
    logic [WORD_BITS-1:0] b_reg;
    logic [WORD_BITS-1:0] r_reg;
    logic [WORD_BITS-1:0] e_reg;
    logic [WORD_BITS-1:0] p_reg;
    logic                 mm_start;
    logic [WORD_BITS-1:0] mm_x;
    logic [WORD_BITS-1:0] mm_y;
    logic [WORD_BITS-1:0] mm_p;
    logic                 mm_done;
    logic [WORD_BITS-1:0] mm_prod;

    msr_mmul #(.WORD_BITS(WORD_BITS)) u_mmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .x     (mm_x),
        .y     (mm_y),
        .p     (mm_p),
        .done  (mm_done),
        .prod  (mm_prod)
    );

    assign mm_p = (state_reg == msr_pkg::EX_IDLE) ? p : p_reg;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        mm_start   = 1'b0;
        mm_x       = b_reg;
        mm_y       = b_reg;
        unique case (state_reg)
            msr_pkg::EX_IDLE:
            begin
                if (start)
                begin
                    mm_start   = 1'b1;
                    mm_x       = base;
                    mm_y       = WORD_BITS'(1);
                    state_next = msr_pkg::EX_RED;
                end
            end
            msr_pkg::EX_RED:
            begin
                if (mm_done)
                begin
                    state_next = msr_pkg::EX_STEP;
                end
            end
            msr_pkg::EX_STEP:
            begin
                if (e_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = msr_pkg::EX_IDLE;
                end
                else if (e_reg[0])
                begin
                    mm_start   = 1'b1;
                    mm_x       = r_reg;
                    state_next = msr_pkg::EX_MULR;
                end
                else
                begin
                    mm_start   = 1'b1;
                    state_next = msr_pkg::EX_SQ;
                end
            end
            msr_pkg::EX_MULR:
            begin
                if (mm_done)
                begin
                    if (e_reg[WORD_BITS-1:1] == '0)
                    begin
                        done_next  = 1'b1;
                        state_next = msr_pkg::EX_IDLE;
                    end
                    else
                    begin
                        mm_start   = 1'b1;
                        state_next = msr_pkg::EX_SQ;
                    end
                end
            end
            msr_pkg::EX_SQ:
            begin
                if (mm_done)
                begin
                    state_next = msr_pkg::EX_STEP;
                end
            end
            default:
            begin
                state_next = msr_pkg::EX_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msr_pkg::EX_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == msr_pkg::EX_IDLE && start)
        begin
            r_reg <= r0;
            e_reg <= exp_val;
            p_reg <= p;
        end
        if (state_reg == msr_pkg::EX_RED && mm_done)
        begin
            b_reg <= mm_prod;
        end
        if (state_reg == msr_pkg::EX_MULR && mm_done)
        begin
            r_reg <= mm_prod;
        end
        if (state_reg == msr_pkg::EX_SQ && mm_done)
        begin
            b_reg <= mm_prod;
            e_reg <= {1'b0, e_reg[WORD_BITS-1:1]};
        end
    end

    assign busy   = (state_reg != msr_pkg::EX_IDLE);
    assign done   = done_reg;
    assign result = r_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == msr_pkg::EX_IDLE)
        else $error("start while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == msr_pkg::EX_IDLE)
        else $error("done while busy");
    a_sq_halves: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == msr_pkg::EX_SQ && mm_done |=> e_reg == $past(e_reg) >> 1)
        else $error("exponent not shifted");

endmodule
